>>> sv/splt_pkg.sv
// Package for the command line word splitter: beat types, queue entry
// type, result kinds and character constants. No dependencies.
`default_nettype none

package splt_pkg;

    localparam int MAX_ARGUMENTS_DEF = 255;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_ENDARG = 2'd1;
    localparam logic [1:0] KIND_ENDCMD = 2'd2;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // result mask bits in a queue entry
    localparam int RES_CHAR   = 0;
    localparam int RES_ENDARG = 1;
    localparam int RES_ENDCMD = 2;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_out;
        logic [7:0] arg_index;
        logic [7:0] arg_count;
        logic       final_res;
    } t_out_beat;

    typedef struct packed {
        logic [2:0] res_mask;
        logic [7:0] ch;
        logic [7:0] idx;
        logic [7:0] cnt;
    } t_entry;

endpackage

`default_nettype wire

>>> sv/splt_front.sv
// Front end: accepts input beats, tracks quoting/escape state and packs
// the results of each byte into one queue entry. Depends on splt_pkg.
`default_nettype none

module splt_front #(
    parameter int MAX_ARGUMENTS = splt_pkg::MAX_ARGUMENTS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire splt_pkg::t_in_beat i_in_beat,
    output logic                o_push,
    output splt_pkg::t_entry    o_entry,
    input  wire                 i_full
);
    import splt_pkg::*;

    localparam logic [7:0] ARG_LIMIT = 8'(MAX_ARGUMENTS);

    logic       r_esc, r_sq, r_dq, r_skip, r_text;
    logic [7:0] r_args;
    logic       n_esc, n_sq, n_dq, n_skip, n_text;
    logic [7:0] n_args;
    logic       emit, sp_end, room, ch_v, ea_v, accept;
    logic [7:0] c;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;
    assign c          = i_in_beat.char_in;
    assign room       = r_args < ARG_LIMIT;

    always_comb begin
        n_esc  = r_esc;
        n_sq   = r_sq;
        n_dq   = r_dq;
        n_skip = r_skip;
        emit   = 1'b0;
        sp_end = 1'b0;
        if (r_skip) begin
            n_skip = 1'b0;
            emit   = (c == CH_PERCENT);
        end else if (r_esc) begin
            n_esc = 1'b0;
            emit  = 1'b1;
        end else begin
            case (c)
                CH_BACKSLASH: n_esc = 1'b1;
                CH_PERCENT:   n_skip = 1'b1;
                CH_SQUOTE: begin
                    if (r_dq) emit = 1'b1;
                    else      n_sq = !r_sq;
                end
                CH_DQUOTE: begin
                    if (r_sq) emit = 1'b1;
                    else      n_dq = !r_dq;
                end
                CH_SPACE: begin
                    if (r_sq || r_dq) emit = 1'b1;
                    else              sp_end = 1'b1;
                end
                default: emit = 1'b1;
            endcase
        end
        n_text = emit ? 1'b1 : (sp_end ? 1'b0 : r_text);
        ch_v   = emit && room;
        // a space end and a closing end on the last byte are exclusive
        ea_v   = room && (sp_end || (i_in_beat.last && n_text));
        n_args = r_args + {7'd0, ea_v};
    end

    always_comb begin
        o_entry.res_mask             = '0;
        o_entry.res_mask[RES_CHAR]   = ch_v;
        o_entry.res_mask[RES_ENDARG] = ea_v;
        o_entry.res_mask[RES_ENDCMD] = i_in_beat.last;
        o_entry.ch                   = c;
        o_entry.idx                  = r_args;
        o_entry.cnt                  = n_args;
    end

    assign o_push = accept && (ch_v || ea_v || i_in_beat.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc  <= 1'b0;
            r_sq   <= 1'b0;
            r_dq   <= 1'b0;
            r_skip <= 1'b0;
            r_text <= 1'b0;
            r_args <= '0;
        end else if (accept) begin
            if (i_in_beat.last) begin
                r_esc  <= 1'b0;
                r_sq   <= 1'b0;
                r_dq   <= 1'b0;
                r_skip <= 1'b0;
                r_text <= 1'b0;
                r_args <= '0;
            end else begin
                r_esc  <= n_esc;
                r_sq   <= n_sq;
                r_dq   <= n_dq;
                r_skip <= n_skip;
                r_text <= n_text;
                r_args <= n_args;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/splt_queue.sv
// Small FIFO of result entries between front and back ends.
// Depends on splt_pkg. DEPTH must be a power of two, at least 2.
`default_nettype none

module splt_queue #(
    parameter int DEPTH = splt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire splt_pkg::t_entry i_entry,
    output logic              o_full,
    input  wire               i_pop,
    output splt_pkg::t_entry  o_head,
    output logic              o_empty
);
    import splt_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [AW:0]   r_wr, r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign o_head  = r_mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr[AW-1:0]] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_full) r_wr <= r_wr + 1'b1;
            if (i_pop && !o_empty) r_rd <= r_rd + 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> sv/splt_back.sv
// Back end: unpacks the queue head into result beats, one per cycle
// while the output is not stalled, through an output register. Depends on splt_pkg.
`default_nettype none

module splt_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire splt_pkg::t_entry i_head,
    input  wire                 i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output splt_pkg::t_out_beat o_out_beat
);
    import splt_pkg::*;

    logic [2:0] r_done;
    logic       r_ov;
    t_out_beat  r_out;
    logic [2:0] pend, sel;
    logic       load, fin;
    t_out_beat  n_out;

    assign pend = i_head.res_mask & ~r_done;
    assign load = (!r_ov || !i_out_stall) && !i_empty;

    always_comb begin
        sel = '0;
        if (pend[RES_CHAR])        sel[RES_CHAR]   = 1'b1;
        else if (pend[RES_ENDARG]) sel[RES_ENDARG] = 1'b1;
        else                       sel[RES_ENDCMD] = 1'b1;
        fin = ((pend & ~sel) == 3'b000);

        n_out.final_res = fin;
        n_out.char_out  = '0;
        n_out.arg_index = i_head.idx;
        n_out.arg_count = '0;
        if (sel[RES_CHAR]) begin
            n_out.kind     = KIND_CHAR;
            n_out.char_out = i_head.ch;
        end else if (sel[RES_ENDARG]) begin
            n_out.kind = KIND_ENDARG;
        end else begin
            n_out.kind      = KIND_ENDCMD;
            n_out.arg_index = '0;
            n_out.arg_count = i_head.cnt;
        end
    end

    assign o_pop       = load && fin;
    assign o_out_valid = r_ov;
    assign o_out_beat  = r_out;

    always_ff @(posedge i_clk) begin
        if (load) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_done <= '0;
        end else begin
            if (load)              r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
            if (load) r_done <= fin ? 3'b000 : (r_done | sel);
        end
    end

endmodule

`default_nettype wire

>>> sv/command_line_word_splitter_core.sv
// Top level of the command line word splitter: front end, entry queue,
// back end. Depends on splt_pkg, splt_front, splt_queue, splt_back.
//
//   channel | direction | handshake               | payload
//   in      | input     | i_in_valid / o_in_stall  | i_in_beat  (t_in_beat)
//   out     | output    | o_out_valid / i_out_stall| o_out_beat (t_out_beat)
//
// One input byte is taken per cycle while the entry queue has room.
// Results leave one per cycle while the output is not stalled; a final byte gives up
// to three, which holds the input back only once the queue fills.
// An input beat's first result passes through the queue memory, then the output register.
// Reset is synchronous, active low, and clears parser state, the queue and the output stage.
// A stalled output holds its beat; the front keeps working until full.
`default_nettype none

module command_line_word_splitter_core #(
    parameter int MAX_ARGUMENTS = splt_pkg::MAX_ARGUMENTS_DEF,
    parameter int QUEUE_DEPTH   = splt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire splt_pkg::t_in_beat i_in_beat,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output splt_pkg::t_out_beat o_out_beat
);
    import splt_pkg::*;

    logic   push, full, pop, empty;
    t_entry entry, head;

    splt_front #(.MAX_ARGUMENTS(MAX_ARGUMENTS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .o_push     (push),
        .o_entry    (entry),
        .i_full     (full)
    );

    splt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    splt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule

`default_nettype wire

>>> sv/splt_checker.sv
// Port-level checker for command_line_word_splitter_core, bound to it.
// Depends on splt_pkg.
`default_nettype none

module splt_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input wire splt_pkg::t_out_beat o_out_beat
);
    import splt_pkg::*;

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped under stall");

    a_beat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_beat))
        else $error("output beat changed under stall");

    a_endcmd_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.kind == KIND_ENDCMD |->
            o_out_beat.final_res && o_out_beat.char_out == 8'd0 &&
            o_out_beat.arg_index == 8'd0)
        else $error("bad end-of-command beat");

    a_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.kind != KIND_ENDCMD |->
            o_out_beat.arg_count == 8'd0)
        else $error("arg_count set outside end of command");

endmodule

bind command_line_word_splitter_core splt_checker u_splt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

`default_nettype wire
